// ===== rtl/core/differential_pd_fan_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Differential PD fan controller assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_PD_FAN_CONTROLLER_DEFINES_SVH
`define DIFFERENTIAL_PD_FAN_CONTROLLER_DEFINES_SVH

// Check outside reset.
`define PDFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every edge, reset included.
`define PDFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/pdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfc_pkg
// Types and constants of the differential PD fan controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdfc_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int DUTY_BITS    = 10;
  localparam int GAIN_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PROP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DERIV_RATIO     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_MAX        = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_DUTY_MIN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_DUTY_MIN  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_IDLE_DUTY = 3'd5;

  // Reset values
  localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST       = 16'd640;
  localparam logic [GAIN_BITS-1:0] DERIV_RATIO_RST     = 16'd3328;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX_RST        = 10'd800;
  localparam logic [DUTY_BITS-1:0] LEFT_DUTY_MIN_RST   = 10'd200;
  localparam logic [DUTY_BITS-1:0] RIGHT_DUTY_MIN_RST  = 10'd220;
  localparam logic [DUTY_BITS-1:0] RIGHT_IDLE_DUTY_RST = 10'd260;

  typedef enum logic [1:0] {
    SIDE_BAL   = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_D,
    ST_SUM,
    ST_MUL_P,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_distance;
    logic [SAMPLE_BITS-1:0] right_distance;
  } pd_in_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] left_duty;
    logic [DUTY_BITS-1:0] right_duty;
    logic [1:0]           active_side;
  } pd_out_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] prop_gain;
    logic [GAIN_BITS-1:0] deriv_ratio;
    logic [DUTY_BITS-1:0] duty_max;
    logic [DUTY_BITS-1:0] left_duty_min;
    logic [DUTY_BITS-1:0] right_duty_min;
    logic [DUTY_BITS-1:0] right_idle_duty;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic calc_diff;
    logic mul_deriv;
    logic calc_mag;
    logic mul_gain;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic balanced;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/differential_pd_fan_controller.sv =====
// ----------------------------------------------------------------------------
// differential_pd_fan_controller
// Two-fan PD controller driven by the difference of two distance samples.
// ----------------------------------------------------------------------------
// An item is taken when the block is idle, and the next one is taken only once
// the last is loaded into the output register (equal samples skip the multiplier):
// the regulated side's duty needs two passes through one shared multiplier,
// first derivative ratio times the error change, then proportional gain times
// the combined term, each pass registered. The result waits in an output
// register, so a new item is accepted while the previous result is untaken;
// the block stalls only if a second result is ready before the first leaves.
// Configuration registers are written at any time through their own port,
// which is always ready, and must only change while no item is in flight.
`default_nettype none

module differential_pd_fan_controller import pdfc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire pd_in_t                  in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output pd_out_t                      out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [GAIN_BITS-1:0]    cfg_data_i
);

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;

  pdfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pdfc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  pdfc_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pdfc_cfg.sv =====
// ----------------------------------------------------------------------------
// pdfc_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module pdfc_cfg import pdfc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [GAIN_BITS-1:0]    cfg_data_i,
  output cfg_t                         cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROP_GAIN:       cfg_d.prop_gain       = cfg_data_i;
        CFG_DERIV_RATIO:     cfg_d.deriv_ratio     = cfg_data_i;
        CFG_DUTY_MAX:        cfg_d.duty_max        = cfg_data_i[DUTY_BITS-1:0];
        CFG_LEFT_DUTY_MIN:   cfg_d.left_duty_min   = cfg_data_i[DUTY_BITS-1:0];
        CFG_RIGHT_DUTY_MIN:  cfg_d.right_duty_min  = cfg_data_i[DUTY_BITS-1:0];
        CFG_RIGHT_IDLE_DUTY: cfg_d.right_idle_duty = cfg_data_i[DUTY_BITS-1:0];
        default:             cfg_d = cfg_q;  // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= PROP_GAIN_RST;
      cfg_q.deriv_ratio     <= DERIV_RATIO_RST;
      cfg_q.duty_max        <= DUTY_MAX_RST;
      cfg_q.left_duty_min   <= LEFT_DUTY_MIN_RST;
      cfg_q.right_duty_min  <= RIGHT_DUTY_MIN_RST;
      cfg_q.right_idle_duty <= RIGHT_IDLE_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/pdfc_mul.sv =====
// ----------------------------------------------------------------------------
// pdfc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pdfc_mul #(
  parameter int A_W = 29,
  parameter int B_W = 16
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic      [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q, p_d;

  always_comb begin
    p_d = p_q;
    if (en_i) begin
      p_d = (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/core/pdfc_seq.sv =====
// ----------------------------------------------------------------------------
// pdfc_seq
// Sequencer: steps one item through the shared multiplier and owns the
// handshake control.
// ----------------------------------------------------------------------------
`default_nettype none
`include "differential_pd_fan_controller_defines.svh"

module pdfc_seq import pdfc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output ctrl_t        ctrl_o
);

  seq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d        = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ctrl_o.calc_diff = 1'b1;
        state_d          = status_i.balanced ? ST_OUT : ST_MUL_D;
      end
      ST_MUL_D: begin
        ctrl_o.mul_deriv = 1'b1;
        state_d          = ST_SUM;
      end
      ST_SUM: begin
        ctrl_o.calc_mag = 1'b1;
        state_d         = ST_MUL_P;
      end
      ST_MUL_P: begin
        ctrl_o.mul_gain = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (slot_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PDFC_ASSERT(a_load_needs_slot, ctrl_o.load_out |-> (!out_valid_q || out_ready_i), "result loaded over an untaken item")
  `PDFC_ASSERT(a_load_sets_valid, ctrl_o.load_out |=> out_valid_q, "loaded result not presented")
  `PDFC_ASSERT(a_accept_starts, (in_valid_i && in_ready_o) |=> (state_q == ST_DIFF && !in_ready_o), "accepted item did not start")

endmodule

`default_nettype wire

// ===== rtl/core/pdfc_dp.sv =====
// ----------------------------------------------------------------------------
// pdfc_dp
// Datapath: error and derivative, the two passes through the shared
// multiplier, sign handling, clamping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "differential_pd_fan_controller_defines.svh"

module pdfc_dp import pdfc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire ctrl_t   ctrl_i,
  input  wire cfg_t    cfg_i,
  input  wire pd_in_t  in_data_i,
  output status_t      status_o,
  output pd_out_t      out_data_o
);

  localparam int BASE_W = SAMPLE_BITS + GAIN_FRAC_BITS;
  localparam int DER_W  = SAMPLE_BITS + GAIN_BITS;
  localparam int MAG_W  = ((BASE_W > DER_W) ? BASE_W : DER_W) + 1;
  localparam int PROD_W = MAG_W + GAIN_BITS;
  localparam int SH_W   = PROD_W - 2 * GAIN_FRAC_BITS;

  logic [SAMPLE_BITS-1:0] l_q, r_q, e_q, d_mag_q;
  logic [SAMPLE_BITS-1:0] prev_left_q, prev_right_q;
  logic                   d_neg_q, neg_q;
  side_e                  side_q;
  logic [MAG_W-1:0]       mag_q;
  pd_out_t                out_q;

  // error and derivative
  logic                   gt, lt;
  logic [SAMPLE_BITS-1:0] err, prev_sel, d_abs;
  logic [SAMPLE_BITS:0]   d_full, d_negd;
  side_e                  side_d;

  assign gt       = l_q > r_q;
  assign lt       = r_q > l_q;
  assign err      = gt ? (l_q - r_q) : (r_q - l_q);
  assign prev_sel = gt ? prev_left_q : prev_right_q;
  assign d_full   = {1'b0, err} - {1'b0, prev_sel};
  assign d_negd   = '0 - d_full;
  assign d_abs    = d_full[SAMPLE_BITS] ? d_negd[SAMPLE_BITS-1:0] : d_full[SAMPLE_BITS-1:0];
  assign side_d   = gt ? SIDE_LEFT : (lt ? SIDE_RIGHT : SIDE_BAL);

  assign status_o.balanced = (l_q == r_q);

  // shared multiplier
  logic [MAG_W-1:0]     mul_a;
  logic [GAIN_BITS-1:0] mul_b;
  logic [PROD_W-1:0]    prod;

  assign mul_a = ctrl_i.mul_gain ? mag_q : MAG_W'(d_mag_q);
  assign mul_b = ctrl_i.mul_gain ? cfg_i.prop_gain : cfg_i.deriv_ratio;

  pdfc_mul #(
    .A_W (MAG_W),
    .B_W (GAIN_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl_i.mul_deriv || ctrl_i.mul_gain),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // inner term: (e << frac) +/- ratio * |d|, split into sign and magnitude
  logic [MAG_W-1:0] base, der;
  logic [MAG_W:0]   sum, sum_negd;
  logic [MAG_W-1:0] mag_d;

  assign base     = MAG_W'(e_q) << GAIN_FRAC_BITS;
  assign der      = prod[MAG_W-1:0];
  assign sum      = d_neg_q ? ({1'b0, base} - {1'b0, der}) : ({1'b0, base} + {1'b0, der});
  assign sum_negd = '0 - sum;
  assign mag_d    = sum[MAG_W] ? sum_negd[MAG_W-1:0] : sum[MAG_W-1:0];

  // scale back and clamp: upper first, then lower
  logic [SH_W-1:0]      shifted;
  logic [DUTY_BITS-1:0] dmin, capped, duty;
  pd_out_t              out_d;

  assign shifted = prod[PROD_W-1:2*GAIN_FRAC_BITS];
  assign dmin    = (side_q == SIDE_LEFT) ? cfg_i.left_duty_min : cfg_i.right_duty_min;
  assign capped  = (shifted > SH_W'(cfg_i.duty_max)) ? cfg_i.duty_max
                                                     : shifted[DUTY_BITS-1:0];
  assign duty    = (neg_q || capped < dmin) ? dmin : capped;

  always_comb begin
    out_d.active_side = side_q;
    case (side_q)
      SIDE_LEFT: begin
        out_d.left_duty  = duty;
        out_d.right_duty = cfg_i.right_idle_duty;
      end
      SIDE_RIGHT: begin
        out_d.left_duty  = '0;
        out_d.right_duty = duty;
      end
      default: begin
        out_d.left_duty  = '0;
        out_d.right_duty = cfg_i.right_idle_duty;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      l_q <= in_data_i.left_distance;
      r_q <= in_data_i.right_distance;
    end
    if (ctrl_i.calc_diff) begin
      e_q     <= err;
      d_mag_q <= d_abs;
      d_neg_q <= d_full[SAMPLE_BITS];
      side_q  <= side_d;
      neg_q   <= 1'b0;
    end
    if (ctrl_i.calc_mag) begin
      mag_q <= mag_d;
      neg_q <= sum[MAG_W];
    end
    if (ctrl_i.load_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_left_q  <= '0;
      prev_right_q <= '0;
    end else if (ctrl_i.load_out) begin
      if (side_q == SIDE_LEFT) begin
        prev_left_q <= e_q;
      end
      if (side_q == SIDE_RIGHT) begin
        prev_right_q <= e_q;
      end
    end
  end

  assign out_data_o = out_q;

  `PDFC_ASSERT(a_left_floor, (ctrl_i.load_out && side_q == SIDE_LEFT) |=> (out_q.left_duty >= $past(cfg_i.left_duty_min)), "left duty below its minimum")
  `PDFC_ASSERT(a_right_floor, (ctrl_i.load_out && side_q == SIDE_RIGHT) |=> (out_q.right_duty >= $past(cfg_i.right_duty_min) && out_q.left_duty == '0), "right result malformed")
  `PDFC_ASSERT_ALWAYS(a_bal_keeps_prev, (rst_ni && ctrl_i.load_out && side_q == SIDE_BAL) |=> ($stable(prev_left_q) && $stable(prev_right_q)), "balanced item changed history")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: differential PD fan controller testbench
// Sends distance sample pairs under several register settings and predicts
// the left and right duty and the regulated side of every item. Results are
// checked in order against the prediction, and both handshakes idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import pdfc_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int CYCLE_CAP  = 600000;
  localparam int TAIL_WAIT  = 12;
  localparam int SQUEEZE_LEN = 400;
  localparam int FRAC_BITS  = 8;

  // Register indexes that map to no register
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  class duty_scoreboard;
    logic [GAIN_BITS-1:0]   prop_gain;
    logic [GAIN_BITS-1:0]   deriv_ratio;
    logic [DUTY_BITS-1:0]   duty_max;
    logic [DUTY_BITS-1:0]   left_min;
    logic [DUTY_BITS-1:0]   right_min;
    logic [DUTY_BITS-1:0]   right_idle;
    logic [SAMPLE_BITS-1:0] last_left_err;
    logic [SAMPLE_BITS-1:0] last_right_err;
    pd_out_t                expected_duties[$];
    int                     errors;

    function new();
      prop_gain      = PROP_GAIN_RST;
      deriv_ratio    = DERIV_RATIO_RST;
      duty_max       = DUTY_MAX_RST;
      left_min       = LEFT_DUTY_MIN_RST;
      right_min      = RIGHT_DUTY_MIN_RST;
      right_idle     = RIGHT_IDLE_DUTY_RST;
      last_left_err  = '0;
      last_right_err = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] data);
      case (idx)
        CFG_PROP_GAIN:       prop_gain   = data;
        CFG_DERIV_RATIO:     deriv_ratio = data;
        CFG_DUTY_MAX:        duty_max    = data[DUTY_BITS-1:0];
        CFG_LEFT_DUTY_MIN:   left_min    = data[DUTY_BITS-1:0];
        CFG_RIGHT_DUTY_MIN:  right_min   = data[DUTY_BITS-1:0];
        CFG_RIGHT_IDLE_DUTY: right_idle  = data[DUTY_BITS-1:0];
        default: ;
      endcase
    endfunction

    // PD term of one side; all arithmetic in signed 64 bits
    function logic [DUTY_BITS-1:0] side_duty(logic [SAMPLE_BITS-1:0] err,
                                             logic [SAMPLE_BITS-1:0] prev,
                                             logic [DUTY_BITS-1:0] dmin);
      longint e_l, p_l, kp, kd, inner, prod, top, bottom;
      e_l    = longint'(err);
      p_l    = longint'(prev);
      kp     = longint'(prop_gain);
      kd     = longint'(deriv_ratio);
      top    = longint'(duty_max);
      bottom = longint'(dmin);
      inner  = (e_l <<< FRAC_BITS) + kd * (e_l - p_l);
      if (inner < 0) return dmin;
      prod = (inner * kp) >>> (2 * FRAC_BITS);
      if (prod > top) prod = top;
      if (prod < bottom) prod = bottom;
      return prod[DUTY_BITS-1:0];
    endfunction

    function void note_sample(pd_in_t s);
      pd_out_t                exp_d;
      logic [SAMPLE_BITS-1:0] err;
      if (s.left_distance > s.right_distance) begin
        err               = s.left_distance - s.right_distance;
        exp_d.left_duty   = side_duty(err, last_left_err, left_min);
        exp_d.right_duty  = right_idle;
        exp_d.active_side = SIDE_LEFT;
        last_left_err     = err;
      end else if (s.right_distance > s.left_distance) begin
        err               = s.right_distance - s.left_distance;
        exp_d.right_duty  = side_duty(err, last_right_err, right_min);
        exp_d.left_duty   = '0;
        exp_d.active_side = SIDE_RIGHT;
        last_right_err    = err;
      end else begin
        exp_d.left_duty   = '0;
        exp_d.right_duty  = right_idle;
        exp_d.active_side = SIDE_BAL;
      end
      expected_duties.push_back(exp_d);
    endfunction

    function void check_duties(pd_out_t got);
      pd_out_t exp_d;
      if (expected_duties.size() == 0) begin
        $error("unexpected result: left_duty %0d right_duty %0d active_side %0d",
               got.left_duty, got.right_duty, got.active_side);
        errors++;
        return;
      end
      exp_d = expected_duties.pop_front();
      if (got.left_duty !== exp_d.left_duty) begin
        $error("left_duty: expected %0d, actual %0d", exp_d.left_duty, got.left_duty);
        errors++;
      end
      if (got.right_duty !== exp_d.right_duty) begin
        $error("right_duty: expected %0d, actual %0d", exp_d.right_duty, got.right_duty);
        errors++;
      end
      if (got.active_side !== exp_d.active_side) begin
        $error("active_side: expected %0d, actual %0d", exp_d.active_side,
               got.active_side);
        errors++;
      end
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  pd_in_t                  in_data;
  logic                    out_valid;
  logic                    out_ready;
  pd_out_t                 out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [GAIN_BITS-1:0]    cfg_data;

  duty_scoreboard sb = new();

  bit calm;
  bit squeeze_req;
  bit squeeze_done;
  int hold_left;
  int cycles;
  int drift_err;

  differential_pd_fan_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Sample all three channels on the falling edge ahead of the edge that completes them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_duties(out_data);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_LEN;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Leaves the item on the bus; the caller lowers valid after the last one
  task automatic send_sample(pd_in_t s);
    int gap;
    gap = (!calm && $urandom_range(99) < 36) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
  endtask

  // Duty registers get junk above their width, which must be dropped
  task automatic load_setting(logic [GAIN_BITS-1:0] kp, logic [GAIN_BITS-1:0] kd,
                              logic [DUTY_BITS-1:0] dmax, logic [DUTY_BITS-1:0] lmin,
                              logic [DUTY_BITS-1:0] rmin, logic [DUTY_BITS-1:0] ridle);
    logic [GAIN_BITS-DUTY_BITS-1:0] junk;
    junk = (GAIN_BITS-DUTY_BITS)'($urandom);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_DERIV_RATIO, kd);
    write_reg(CFG_DUTY_MAX, {junk, dmax});
    junk = (GAIN_BITS-DUTY_BITS)'($urandom);
    write_reg(CFG_LEFT_DUTY_MIN, {junk, lmin});
    junk = (GAIN_BITS-DUTY_BITS)'($urandom);
    write_reg(CFG_RIGHT_DUTY_MIN, {junk, rmin});
    junk = (GAIN_BITS-DUTY_BITS)'($urandom);
    write_reg(CFG_RIGHT_IDLE_DUTY, {junk, ridle});
    write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait out every expected result and the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  function automatic int clip_sample(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic pd_in_t pick_sample();
    pd_in_t s;
    int     base, off, pick;
    pick = $urandom_range(99);
    base = $urandom_range(4095);
    if (pick < 40) begin
      // small error around a random level
      off = $urandom_range(128);
      off = off - 64;
      s.left_distance  = SAMPLE_BITS'(clip_sample(base + off));
      s.right_distance = SAMPLE_BITS'(base);
    end else if (pick < 52) begin
      s.left_distance  = SAMPLE_BITS'(base);
      s.right_distance = SAMPLE_BITS'(base);
    end else if (pick < 75) begin
      // slowly drifting error so the derivative term stays small
      off       = $urandom_range(40);
      drift_err = drift_err + off - 20;
      if (drift_err > 600) drift_err = 600;
      if (drift_err < -600) drift_err = -600;
      s.left_distance  = SAMPLE_BITS'(base);
      s.right_distance = SAMPLE_BITS'(clip_sample(base - drift_err));
    end else begin
      s.left_distance  = SAMPLE_BITS'($urandom);
      s.right_distance = SAMPLE_BITS'($urandom);
    end
    return s;
  endfunction

  task automatic run_random(int n, bit calm_mid, bit squeeze);
    for (int i = 0; i < n; i++) begin
      if (calm_mid) calm = (i >= n / 4) && (i < n / 2);
      if (squeeze && i == 20) squeeze_req = 1'b1;
      send_sample(pick_sample());
    end
    calm = 1'b0;
  endtask

  int pts[22][2] = '{
    '{0, 0}, '{4095, 0}, '{0, 4095}, '{4095, 4095}, '{1, 0}, '{0, 1},
    '{2, 0}, '{0, 2}, '{100, 100}, '{3, 0}, '{0, 60}, '{10, 0},
    '{4000, 3990}, '{0, 3000}, '{2048, 2047}, '{2047, 2048}, '{4095, 1},
    '{1, 4095}, '{7, 7}, '{50, 40}, '{30, 0}, '{0, 0}
  };

  initial begin
    pd_in_t s;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: sign changes, full-scale errors, side swaps, balance
    foreach (pts[i]) begin
      s.left_distance  = SAMPLE_BITS'(pts[i][0]);
      s.right_distance = SAMPLE_BITS'(pts[i][1]);
      send_sample(s);
    end
    run_random(150, 1'b0, 1'b0);
    drain();

    load_setting(16'd64, 16'd256, 10'd1023, 10'd0, 10'd0, 10'd0);
    run_random(200, 1'b1, 1'b0);
    drain();

    load_setting(16'd0, 16'd65535, 10'd800, 10'd5, 10'd1023, 10'd1023);
    run_random(100, 1'b0, 1'b0);
    drain();

    load_setting(16'd65535, 16'd65535, 10'd1023, 10'd0, 10'd0, 10'd512);
    run_random(100, 1'b0, 1'b0);
    drain();

    load_setting(16'($urandom_range(8, 200)), 16'd0, 10'($urandom_range(300, 1023)),
                 10'($urandom_range(100)), 10'($urandom_range(100)), 10'($urandom));
    run_random(200, 1'b0, 1'b1);
    drain();

    // minimum above maximum: the minimum wins
    load_setting(16'd300, 16'd512, 10'd0, 10'd1023, 10'd300, 10'd1);
    run_random(100, 1'b0, 1'b0);
    drain();

    load_setting(16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom),
                 10'($urandom), 10'($urandom));
    run_random(150, 1'b0, 1'b0);
    drain();

    load_setting(16'd32, 16'd4096, 10'd900, 10'd50, 10'd70, 10'd333);
    run_random(230, 1'b1, 1'b0);
    drain();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
